[hdl/u8dec_pkg.sv]
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types, constants and helpers for the utf-8 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned PEND_DEPTH = 5;

    typedef logic [2:0]  len_t;
    typedef logic [2:0]  pidx_t;
    typedef logic [7:0]  byte_t;
    typedef logic [20:0] cp_t;

    localparam cp_t   REPL_CP   = 21'd63;
    localparam cp_t   MIN_CP2   = 21'h000080;
    localparam cp_t   MIN_CP3   = 21'h000800;
    localparam cp_t   SURR_LO   = 21'h00D800;
    localparam cp_t   SURR_HI   = 21'h00DBFF;
    localparam cp_t   MIN_CP4   = 21'h010000;
    localparam cp_t   MAX_CP    = 21'h10FFFF;
    localparam len_t  LEN_NONE  = 3'd0;
    localparam len_t  LEN_ONE   = 3'd1;
    localparam len_t  LEN_TWO   = 3'd2;
    localparam len_t  LEN_THREE = 3'd3;
    localparam len_t  LEN_FOUR  = 3'd4;
    localparam len_t  LEN_FIVE  = 3'd5;
    localparam len_t  LEN_SIX   = 3'd6;

    // source of the value loaded into the output register
    typedef enum logic [2:0] {
        SEL_BYTE,
        SEL_IN_FALLBACK,
        SEL_DECODE,
        SEL_PEND_FALLBACK,
        SEL_PEND_IDX,
        SEL_HELD
    } out_sel_t;

    typedef struct packed {
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
        logic     start_in;
        logic     start_held;
        logic     append;
        logic     go_idle;
        logic     hold;
        logic     idx_init;
        logic     idx_inc;
    } cmd_t;

    typedef struct packed {
        logic open;
        logic in_cont;
        logic in_raw;
        logic in_eos;
        logic in_fresh_emits;
        logic complete;
        logic single;
        logic flush_last;
    } sts_t;

    function automatic len_t form_len(input byte_t b);
        len_t len;
        priority if (b < 8'h80)  len = LEN_ONE;
        else if (b < 8'hC0)      len = LEN_NONE;
        else if (b < 8'hE0)      len = LEN_TWO;
        else if (b < 8'hF0)      len = LEN_THREE;
        else if (b < 8'hF8)      len = LEN_FOUR;
        else if (b < 8'hFC)      len = LEN_FIVE;
        else if (b < 8'hFE)      len = LEN_SIX;
        else                     len = LEN_NONE;
        return len;
    endfunction

    // lead byte value for short forms, replacement for 5- and 6-byte forms
    function automatic cp_t fallback(input byte_t b, input len_t len);
        cp_t v;
        if (len >= LEN_FIVE) v = REPL_CP;
        else                 v = {13'd0, b};
        return v;
    endfunction

endpackage

[hdl/u8dec_datapath.sv]
// ----------------------------------------------------------------------------
// u8dec_datapath
// Pending byte store, form counters, decode logic and output register.
// ----------------------------------------------------------------------------
module u8dec_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  logic                end_of_string,
    input  u8dec_pkg::cmd_t     cmd,
    output u8dec_pkg::sts_t     sts,
    output logic [20:0]         code_point,
    output logic                last_of_run
);

    u8dec_pkg::byte_t pend_reg [u8dec_pkg::PEND_DEPTH];
    u8dec_pkg::byte_t pend_next [u8dec_pkg::PEND_DEPTH];
    u8dec_pkg::len_t  cnt_reg, cnt_next;
    u8dec_pkg::len_t  exp_reg, exp_next;
    u8dec_pkg::pidx_t idx_reg, idx_next;
    u8dec_pkg::byte_t held_reg, held_next;
    u8dec_pkg::cp_t   cp_reg, cp_next;
    logic             last_reg, last_next;

    u8dec_pkg::len_t  in_len;
    u8dec_pkg::len_t  held_len;
    u8dec_pkg::cp_t   dec_val;
    logic [10:0]      v2;
    logic [15:0]      v3;
    logic [20:0]      v4;

    assign in_len   = u8dec_pkg::form_len(data_byte);
    assign held_len = u8dec_pkg::form_len(held_reg);

    assign sts.open           = (exp_reg != u8dec_pkg::LEN_NONE);
    assign sts.in_cont        = (data_byte[7:6] == 2'b10);
    assign sts.in_raw         = (in_len <= u8dec_pkg::LEN_ONE);
    assign sts.in_eos         = end_of_string;
    assign sts.in_fresh_emits = sts.in_raw || end_of_string;
    assign sts.complete       = (u8dec_pkg::len_t'(cnt_reg + 3'd1) == exp_reg);
    assign sts.single         = (cnt_reg == u8dec_pkg::LEN_ONE);
    assign sts.flush_last     = (idx_reg == u8dec_pkg::pidx_t'(cnt_reg - 3'd1));

    // the incoming byte is the final continuation of the open form
    assign v2 = {pend_reg[0][4:0], data_byte[5:0]};
    assign v3 = {pend_reg[0][3:0], pend_reg[1][5:0], data_byte[5:0]};
    assign v4 = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], data_byte[5:0]};

    always_comb
    begin
        dec_val = u8dec_pkg::REPL_CP;
        unique case (exp_reg)
            u8dec_pkg::LEN_TWO:
            begin
                if ({10'd0, v2} >= u8dec_pkg::MIN_CP2)
                    dec_val = {10'd0, v2};
            end
            u8dec_pkg::LEN_THREE:
            begin
                if ({5'd0, v3} >= u8dec_pkg::MIN_CP3
                    && !({5'd0, v3} >= u8dec_pkg::SURR_LO
                         && {5'd0, v3} <= u8dec_pkg::SURR_HI))
                    dec_val = {5'd0, v3};
            end
            u8dec_pkg::LEN_FOUR:
            begin
                if (v4 >= u8dec_pkg::MIN_CP4 && v4 <= u8dec_pkg::MAX_CP)
                    dec_val = v4;
            end
            default:
            begin
                dec_val = u8dec_pkg::REPL_CP;
            end
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        exp_next  = exp_reg;
        idx_next  = idx_reg;
        held_next = held_reg;
        cp_next   = cp_reg;
        last_next = last_reg;
        for (int i = 0; i < u8dec_pkg::PEND_DEPTH; i++)
            pend_next[i] = pend_reg[i];

        priority if (cmd.go_idle)
        begin
            cnt_next = u8dec_pkg::LEN_NONE;
            exp_next = u8dec_pkg::LEN_NONE;
        end
        else if (cmd.start_in)
        begin
            pend_next[0] = data_byte;
            cnt_next     = u8dec_pkg::LEN_ONE;
            exp_next     = in_len;
        end
        else if (cmd.start_held)
        begin
            pend_next[0] = held_reg;
            cnt_next     = u8dec_pkg::LEN_ONE;
            exp_next     = held_len;
        end
        else if (cmd.append)
        begin
            for (int i = 0; i < u8dec_pkg::PEND_DEPTH; i++)
                if (cnt_reg == u8dec_pkg::pidx_t'(i))
                    pend_next[i] = data_byte;
            cnt_next = u8dec_pkg::len_t'(cnt_reg + 3'd1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        if (cmd.hold)
            held_next = data_byte;

        priority if (cmd.idx_init)
            idx_next = 3'd1;
        else if (cmd.idx_inc)
            idx_next = u8dec_pkg::pidx_t'(idx_reg + 3'd1);
        else
            idx_next = idx_reg;

        if (cmd.out_load)
        begin
            last_next = cmd.out_last;
            unique case (cmd.out_sel)
                u8dec_pkg::SEL_BYTE:          cp_next = {13'd0, data_byte};
                u8dec_pkg::SEL_IN_FALLBACK:   cp_next = u8dec_pkg::fallback(data_byte, in_len);
                u8dec_pkg::SEL_DECODE:        cp_next = dec_val;
                u8dec_pkg::SEL_PEND_FALLBACK: cp_next = u8dec_pkg::fallback(pend_reg[0], exp_reg);
                u8dec_pkg::SEL_PEND_IDX:      cp_next = {13'd0, pend_reg[idx_reg]};
                u8dec_pkg::SEL_HELD:
                begin
                    if (held_len <= u8dec_pkg::LEN_ONE)
                        cp_next = {13'd0, held_reg};
                    else
                        cp_next = u8dec_pkg::fallback(held_reg, held_len);
                end
                default:                      cp_next = u8dec_pkg::REPL_CP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= u8dec_pkg::LEN_NONE;
            exp_reg <= u8dec_pkg::LEN_NONE;
            idx_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < u8dec_pkg::PEND_DEPTH; i++)
            pend_reg[i] <= pend_next[i];
        held_reg <= held_next;
        cp_reg   <= cp_next;
        last_reg <= last_next;
    end

    assign code_point  = cp_reg;
    assign last_of_run = last_reg;

endmodule

[hdl/u8dec_ctrl.sv]
// ----------------------------------------------------------------------------
// u8dec_ctrl
// Controller: handshakes, replay sequencing and output valid.
// ----------------------------------------------------------------------------
module u8dec_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    output logic                cp_valid,
    input  logic                cp_stall,
    input  u8dec_pkg::sts_t     sts,
    output u8dec_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_FLUSH = 2'd1;
    localparam logic [1:0] S_TAIL  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       tail_reg, tail_next;
    logic       start_reg, start_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_ready;
    logic       take;

    assign out_ready  = !out_valid_reg || !cp_stall;
    assign byte_stall = !((state_reg == S_RUN) && out_ready);
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = u8dec_pkg::SEL_BYTE;
        state_next  = state_reg;
        tail_next   = tail_reg;
        start_next  = start_reg;

        unique case (state_reg)
            S_RUN:
            begin
                if (take)
                begin
                    if (!sts.open)
                    begin
                        if (sts.in_fresh_emits)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            cmd.out_sel  = sts.in_raw ? u8dec_pkg::SEL_BYTE
                                                      : u8dec_pkg::SEL_IN_FALLBACK;
                        end
                        else
                        begin
                            cmd.start_in = 1'b1;
                        end
                    end
                    else if (sts.in_cont)
                    begin
                        if (sts.complete)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            cmd.out_sel  = u8dec_pkg::SEL_DECODE;
                            cmd.go_idle  = 1'b1;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            // cut off by end of string: replay lead and held bytes
                            if (sts.in_eos)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = u8dec_pkg::SEL_PEND_FALLBACK;
                                cmd.idx_init = 1'b1;
                                tail_next    = 1'b0;
                                start_next   = 1'b0;
                                state_next   = S_FLUSH;
                            end
                        end
                    end
                    else
                    begin
                        // broken form: lead fallback, held bytes, then any new word
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = u8dec_pkg::SEL_PEND_FALLBACK;
                        cmd.hold     = 1'b1;
                        if (sts.single)
                        begin
                            if (sts.in_fresh_emits)
                            begin
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                cmd.out_last = 1'b1;
                                cmd.start_in = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.idx_init = 1'b1;
                            tail_next    = sts.in_fresh_emits;
                            start_next   = !sts.in_fresh_emits;
                            state_next   = S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = u8dec_pkg::SEL_PEND_IDX;
                    cmd.idx_inc  = 1'b1;
                    if (sts.flush_last)
                    begin
                        cmd.out_last = !tail_reg;
                        if (tail_reg)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            cmd.start_held = start_reg;
                            cmd.go_idle    = !start_reg;
                            state_next     = S_RUN;
                        end
                    end
                end
            end
            S_TAIL:
            begin
                if (out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_sel  = u8dec_pkg::SEL_HELD;
                    cmd.go_idle  = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!cp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            tail_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cp_valid = out_valid_reg;

endmodule

[hdl/utf8_to_code_point_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_top
// Utf-8 byte stream to code point decoder with error replay.
// ----------------------------------------------------------------------------
// a result is registered and shown in the cycle after its completing byte
// throughput: one byte per cycle, set by the single output register, when
// the output is not stalled; a broken or cut-off form holds the input, one
// replayed word at a time, while the controller walks the pending store
// reset clears the controller and form counters; no clearing pass is needed
module utf8_to_code_point_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    output logic        cp_valid,
    input  logic        cp_stall,
    output logic [20:0] code_point,
    output logic        last_of_run
);

    u8dec_pkg::cmd_t cmd;
    u8dec_pkg::sts_t sts;

    u8dec_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    u8dec_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .cmd           (cmd),
        .sts           (sts),
        .code_point    (code_point),
        .last_of_run   (last_of_run)
    );

endmodule

[hdl/u8dec_checker.sv]
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level assertions for the utf-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8dec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  data_byte,
    input logic        end_of_string,
    input logic        cp_valid,
    input logic        cp_stall,
    input logic [20:0] code_point,
    input logic        last_of_run
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_stall |=> cp_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_stall |=> $stable(code_point) && $stable(last_of_run))
        else $error("output word changed while stalled");

    a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid |-> code_point <= 21'h10FFFF)
        else $error("code point out of range");

    // multibyte values only come from a complete form, the sole result of its final byte
    a_wide_last: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && (code_point > 21'h0000FF) |-> last_of_run)
        else $error("decoded value not marked last of run");

endmodule

bind utf8_to_code_point_decoder_top u8dec_checker u_u8dec_checker (.*);

[test/utf8_to_code_point_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_top_tb
// Self-checking bench for the utf-8 decoder: byte streams in, code points out.
// A local model predicts every code point and its run flag per accepted byte
// and the checker compares each accepted output word in order. Both sides
// idle at random, one phase runs back to back, and one phase holds the output
// off long enough that the decoder has to stall its input.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_top_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        u8dec_pkg::cp_t cp;
        logic           last;
    } cp_word_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             byte_valid    = 1'b0;
    logic             byte_stall;
    u8dec_pkg::byte_t data_byte     = '0;
    logic             end_of_string = 1'b0;
    logic             cp_valid;
    logic             cp_stall      = 1'b0;
    logic [20:0]      code_point;
    logic             last_of_run;

    // decoder model state
    u8dec_pkg::byte_t held_bytes [u8dec_pkg::PEND_DEPTH];
    int               held_cnt = 0;
    u8dec_pkg::len_t  open_len = u8dec_pkg::LEN_NONE;
    cp_word_t         run_words [$];
    cp_word_t         expected_cps [$];

    int tx_idle_pct   = 37;
    int rx_idle_pct   = 37;
    int hold_req_cnt  = 0;
    int hold_done_cnt = 0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int err_cnt       = 0;
    int bytes_sent    = 0;
    int cps_checked   = 0;
    int repl_cnt      = 0;
    int replay_runs   = 0;

    utf8_to_code_point_decoder_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .cp_valid      (cp_valid),
        .cp_stall      (cp_stall),
        .code_point    (code_point),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic u8dec_pkg::len_t lead_len(input u8dec_pkg::byte_t b);
        if (b < 8'h80) return u8dec_pkg::LEN_ONE;
        if (b < 8'hC0) return u8dec_pkg::LEN_NONE;
        if (b < 8'hE0) return u8dec_pkg::LEN_TWO;
        if (b < 8'hF0) return u8dec_pkg::LEN_THREE;
        if (b < 8'hF8) return u8dec_pkg::LEN_FOUR;
        if (b < 8'hFC) return u8dec_pkg::LEN_FIVE;
        if (b < 8'hFE) return u8dec_pkg::LEN_SIX;
        return u8dec_pkg::LEN_NONE;
    endfunction

    function automatic u8dec_pkg::cp_t lead_value(input u8dec_pkg::byte_t b,
                                                  input u8dec_pkg::len_t len);
        return (len >= u8dec_pkg::LEN_FIVE) ? u8dec_pkg::REPL_CP
                                            : u8dec_pkg::cp_t'(b);
    endfunction

    function void emit(input u8dec_pkg::cp_t v);
        run_words.push_back('{v, 1'b0});
    endfunction

    function void close_form();
        held_cnt = 0;
        open_len = u8dec_pkg::LEN_NONE;
    endfunction

    // lead fallback, then every held continuation byte as itself
    function void flush_held();
        if (held_cnt > 0)
        begin
            emit(lead_value(held_bytes[0], open_len));
            for (int i = 1; i < held_cnt; i++)
                emit(u8dec_pkg::cp_t'(held_bytes[i]));
        end
        close_form();
    endfunction

    function void begin_form(input u8dec_pkg::byte_t b, input logic eos);
        u8dec_pkg::len_t len;
        len = lead_len(b);
        if (len <= u8dec_pkg::LEN_ONE)
            emit(u8dec_pkg::cp_t'(b));
        else if (eos)
            emit(lead_value(b, len));
        else
        begin
            held_bytes[0] = b;
            held_cnt = 1;
            open_len = len;
        end
    endfunction

    function automatic u8dec_pkg::cp_t form_value(input u8dec_pkg::byte_t tail);
        u8dec_pkg::cp_t v;
        case (open_len)
            u8dec_pkg::LEN_TWO:
            begin
                v = u8dec_pkg::cp_t'({held_bytes[0][4:0], tail[5:0]});
                if (v < u8dec_pkg::MIN_CP2 || v > 21'h0007FF) v = u8dec_pkg::REPL_CP;
            end
            u8dec_pkg::LEN_THREE:
            begin
                v = u8dec_pkg::cp_t'({held_bytes[0][3:0], held_bytes[1][5:0],
                                      tail[5:0]});
                if (v < u8dec_pkg::MIN_CP3 || v > 21'h00FFFF)
                    v = u8dec_pkg::REPL_CP;
                else if (v >= u8dec_pkg::SURR_LO && v <= u8dec_pkg::SURR_HI)
                    v = u8dec_pkg::REPL_CP;
            end
            u8dec_pkg::LEN_FOUR:
            begin
                v = u8dec_pkg::cp_t'({held_bytes[0][2:0], held_bytes[1][5:0],
                                      held_bytes[2][5:0], tail[5:0]});
                if (v < u8dec_pkg::MIN_CP4 || v > u8dec_pkg::MAX_CP)
                    v = u8dec_pkg::REPL_CP;
            end
            default:
                v = u8dec_pkg::REPL_CP;
        endcase
        return v;
    endfunction

    function void decode_byte(input u8dec_pkg::byte_t b, input logic eos);
        run_words.delete();
        if (open_len < u8dec_pkg::LEN_TWO || open_len > u8dec_pkg::LEN_SIX
            || held_cnt == 0 || held_cnt >= open_len)
        begin
            close_form();
            begin_form(b, eos);
        end
        else if (b >= 8'h80 && b <= 8'hBF)
        begin
            if (held_cnt + 1 == open_len)
            begin
                emit(form_value(b));
                close_form();
            end
            else
            begin
                held_bytes[held_cnt] = b;
                held_cnt++;
                if (eos)
                    flush_held();
            end
        end
        else
        begin
            flush_held();
            begin_form(b, eos);
        end
        if (eos)
            close_form();
        if (run_words.size() > 0)
            run_words[$].last = 1'b1;
        if (run_words.size() > 1)
            replay_runs++;
        foreach (run_words[i])
        begin
            if (run_words[i].cp == u8dec_pkg::REPL_CP)
                repl_cnt++;
            expected_cps.push_back(run_words[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // output side: random stall plus an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            cp_stall  <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req_cnt != hold_done_cnt)
        begin
            cp_stall      <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            hold_done_cnt <= hold_done_cnt + 1;
        end
        else
            cp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin : check_cp
        cp_word_t want;
        if (rst_n && cp_valid && !cp_stall)
        begin
            if (expected_cps.size() == 0)
            begin
                $error("unexpected word: code_point %h last_of_run %b",
                       code_point, last_of_run);
                err_cnt++;
            end
            else
            begin
                want = expected_cps.pop_front();
                cps_checked++;
                if (code_point !== want.cp)
                begin
                    $error("code_point: expected %h, got %h", want.cp, code_point);
                    err_cnt++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %b, got %b", want.last, last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_byte(input u8dec_pkg::byte_t b, input logic eos);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid    <= 1'b1;
        data_byte     <= b;
        end_of_string <= eos;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        decode_byte(b, eos);
        bytes_sent++;
    endtask

    function automatic u8dec_pkg::byte_t random_lead(input int len);
        case (len)
            1: return u8dec_pkg::byte_t'($urandom_range(8'h7F));
            2: return u8dec_pkg::byte_t'($urandom_range(8'hDF, 8'hC0));
            3: return ($urandom_range(3) == 0) ? 8'hED
                          : u8dec_pkg::byte_t'($urandom_range(8'hEF, 8'hE0));
            4: return ($urandom_range(3) == 0) ? 8'hF4
                          : u8dec_pkg::byte_t'($urandom_range(8'hF7, 8'hF0));
            5: return u8dec_pkg::byte_t'($urandom_range(8'hFB, 8'hF8));
            default: return u8dec_pkg::byte_t'($urandom_range(8'hFD, 8'hFC));
        endcase
    endfunction

    function automatic u8dec_pkg::byte_t random_cont();
        return u8dec_pkg::byte_t'($urandom_range(8'hBF, 8'h80));
    endfunction

    // mostly complete forms with random content, plus broken forms and noise
    task automatic send_random_chunk();
        int               kind;
        int               len;
        int               conts;
        u8dec_pkg::byte_t b;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            len = $urandom_range(6, 1);
            send_byte(random_lead(len), $urandom_range(15) == 0);
            for (int i = 1; i < len; i++)
                send_byte(random_cont(), $urandom_range(15) == 0);
        end
        else if (kind < 85)
        begin
            len   = $urandom_range(6, 2);
            conts = $urandom_range(len - 2);
            send_byte(random_lead(len), 1'b0);
            for (int i = 0; i < conts; i++)
                send_byte(random_cont(), 1'b0);
            b = u8dec_pkg::byte_t'($urandom_range(255));
            if (b >= 8'h80 && b <= 8'hBF)
                b = b ^ 8'h40;
            send_byte(b, $urandom_range(7) == 0);
        end
        else
        begin
            for (int i = $urandom_range(2, 0); i >= 0; i--)
                send_byte(u8dec_pkg::byte_t'($urandom_range(255)),
                          $urandom_range(7) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hBF, 1'b0);   // stray continuation
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_complete_forms();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        // highest legal code point
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // high surrogate gets replaced
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        // six-byte form, its last byte also ending the string
        send_byte(8'hFC, 1'b0);
        for (int i = 0; i < 4; i++)
            send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_broken_and_cut_forms();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);   // breaks the open form
        send_byte(8'hF8, 1'b1);   // lead arriving with end of string
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);   // cut off after one continuation
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        stop_at     = bytes_sent + n_bytes;
        tx_idle_pct = 37;
        rx_idle_pct = 37;
        while (bytes_sent < stop_at)
            send_random_chunk();
    endtask

    task automatic test_back_to_back(input int n_bytes);
        int stop_at;
        stop_at     = bytes_sent + n_bytes;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (bytes_sent < stop_at)
            send_random_chunk();
    endtask

    // output held off while bytes keep coming: the decoder must stall its input
    task automatic test_output_hold_off(input int n_bytes);
        int stop_at;
        stop_at     = bytes_sent + n_bytes;
        tx_idle_pct = 0;
        rx_idle_pct = 37;
        hold_req_cnt++;
        while (bytes_sent < stop_at)
            send_random_chunk();
        tx_idle_pct = 37;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes();
        test_complete_forms();
        test_broken_and_cut_forms();
        test_random_traffic(260);
        test_back_to_back(120);
        test_output_hold_off(50);

        byte_valid <= 1'b0;
        rx_idle_pct = 37;
        while (expected_cps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cps.size() > 0)
        begin
            $error("%0d code points never arrived", expected_cps.size());
            err_cnt++;
        end

        $display("sent %0d bytes, checked %0d code points (%0d replacements)",
                 bytes_sent, cps_checked, repl_cnt);
        $display("%0d bytes caused more than one word (replays and fallbacks)",
                 replay_runs);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/u8dec_pkg.sv
hdl/u8dec_datapath.sv
hdl/u8dec_ctrl.sv
hdl/utf8_to_code_point_decoder_top.sv
hdl/u8dec_checker.sv
test/utf8_to_code_point_decoder_top_tb.sv
